FILE: rtl/spcps_pkg.sv
// Shared types, constants and helpers for the serial clock prescale search block.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package spcps_pkg;

    localparam int PRESCALE_BITS_DEF = 13;

    localparam int TGT_W = 32;   // requested frequency width
    localparam int CPU_W = 28;   // system clock in Hz, up to 255e6
    localparam int MHZ_W = 8;
    localparam int DVS_W = 32;   // divider divisor width
    localparam int CNT_W = 5;    // divider step counter width

    localparam logic [MHZ_W-1:0] CPU_MHZ_RESET = 8'd80;
    localparam logic [31:0]      HZ_PER_MHZ    = 32'd1000000;

    typedef enum logic [1:0] {
        DS_2,
        DS_3,
        DS_5
    } dsel_t;

    typedef enum logic [1:0] {
        DK_START,
        DK_NEED,
        DK_FREQ
    } dkind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_GO,
        S_WAIT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic   capture;
        logic   div_go;
        dkind_t kind;
        dsel_t  dsel;
        logic   finish;
    } cmd_t;

    typedef struct packed {
        logic sysclk;
        logic div_done;
    } stat_t;

    function automatic logic [2:0] div_value(input dsel_t d);
        logic [2:0] v;
        begin
            case (d)
                DS_2:    v = 3'd2;
                DS_3:    v = 3'd3;
                DS_5:    v = 3'd5;
                default: v = 3'd5;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: rtl/spcps_div.sv
// Restoring radix-2 divider: quotient of a CPU_W-bit dividend by a DVS_W-bit divisor.
// One quotient bit per cycle; depends on spcps_pkg.
`timescale 1ns / 1ps

module spcps_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic [spcps_pkg::CPU_W-1:0]  dividend,
    input  logic [spcps_pkg::DVS_W-1:0]  divisor,
    output logic                         done,
    output logic [spcps_pkg::CPU_W-1:0]  quotient
);

    localparam int QW = spcps_pkg::CPU_W;
    localparam int RW = spcps_pkg::DVS_W;
    localparam int CW = spcps_pkg::CNT_W;

    logic [RW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [RW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [RW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[QW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (go)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // a zero divisor always fits and yields an all-ones quotient
            rem_next = fits ? RW'(trial - {1'b0, dvs_reg}) : RW'(trial);
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/spcps_dp.sv
// Datapath: clock register, operand formation, shared divider, candidate store,
// candidate choice and result register. Depends on spcps_pkg and spcps_div.
`timescale 1ns / 1ps

module spcps_dp #(
    parameter int PRESCALE_BITS = spcps_pkg::PRESCALE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [spcps_pkg::MHZ_W-1:0]  cfg_data,
    input  logic [spcps_pkg::TGT_W-1:0]  target_freq_hz,
    input  spcps_pkg::cmd_t              cmd,
    output spcps_pkg::stat_t             stat,
    output logic [27:0]                  achieved_freq_hz,
    output logic                         sysclk_mode,
    output logic [PRESCALE_BITS-1:0]     prescale_minus_one,
    output logic [2:0]                   divisor_minus_one,
    output logic                         range_error
);

    localparam int CW = spcps_pkg::CPU_W;
    localparam int DW = spcps_pkg::DVS_W;
    localparam int PW = PRESCALE_BITS + 1;
    localparam logic [CW:0] MAXP = (CW+1)'(1) << PRESCALE_BITS;

    logic [spcps_pkg::MHZ_W-1:0] cpu_mhz_reg;
    logic [CW-1:0]               cpu_reg;
    logic [spcps_pkg::TGT_W-1:0] f_reg;
    logic [CW-1:0]               start_reg;
    logic [PW-1:0]               pre_reg  [0:2];
    logic                        sat_reg  [0:2];
    logic [CW-1:0]               freq_reg [0:2];

    logic [27:0]               ach_reg;
    logic                      sys_reg;
    logic [PRESCALE_BITS-1:0]  pm1_reg;
    logic [2:0]                dm1_reg;
    logic                      rerr_reg;

    logic [2:0]    dv;
    logic [CW-1:0] f28;
    logic [DW-1:0] divisor;
    logic          div_done;
    logic [CW-1:0] quo;
    logic          sysclk;

    logic [CW-1:0] start_c;
    logic [CW:0]   need_full;
    logic [CW:0]   pre_full;
    logic          sat_c;
    logic [PW-1:0] pre_c;

    logic               alt_is3;
    spcps_pkg::dsel_t   alt_sel;
    spcps_pkg::dsel_t   best_sel;
    logic               take_alt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_mhz_reg <= spcps_pkg::CPU_MHZ_RESET;
        end
        else if (cfg_we)
        begin
            cpu_mhz_reg <= cfg_data;
        end
    end

    assign f28    = f_reg[CW-1:0];
    assign dv     = spcps_pkg::div_value(cmd.dsel);
    assign sysclk = f_reg >= spcps_pkg::TGT_W'(cpu_reg);

    always_comb
    begin
        unique case (cmd.kind)
            spcps_pkg::DK_START: divisor = DW'(f28) * DW'(dv);
            spcps_pkg::DK_NEED:  divisor = (DW'(f28) + DW'(1)) * DW'(dv);
            spcps_pkg::DK_FREQ:  divisor = DW'(pre_reg[cmd.dsel]) * DW'(dv);
            default:             divisor = '0;
        endcase
    end

    spcps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend (cpu_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quo)
    );

    // prescale = max(start, 1, need), saturated at 2^PRESCALE_BITS
    always_comb
    begin
        start_c   = (start_reg == '0) ? CW'(1) : start_reg;
        need_full = (CW+1)'(quo) + (CW+1)'(1);
        pre_full  = ((CW+1)'(start_c) > need_full) ? (CW+1)'(start_c) : need_full;
        sat_c     = pre_full > MAXP;
        pre_c     = sat_c ? PW'(MAXP) : PW'(pre_full);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            f_reg   <= target_freq_hz;
            cpu_reg <= CW'(32'(cpu_mhz_reg) * spcps_pkg::HZ_PER_MHZ);
        end
        if (div_done)
        begin
            case (cmd.kind)
                spcps_pkg::DK_START: start_reg <= quo;
                spcps_pkg::DK_NEED:
                begin
                    pre_reg[cmd.dsel] <= pre_c;
                    sat_reg[cmd.dsel] <= sat_c;
                end
                default: freq_reg[cmd.dsel] <= quo;
            endcase
        end
    end

    // unsaturated beats saturated; among saturated, divisor 5 wins; a speed tie goes to 5 over 3 and to 2 over either
    always_comb
    begin
        if (sat_reg[spcps_pkg::DS_3] && sat_reg[spcps_pkg::DS_5])
            alt_is3 = 1'b0;
        else if (sat_reg[spcps_pkg::DS_3] != sat_reg[spcps_pkg::DS_5])
            alt_is3 = !sat_reg[spcps_pkg::DS_3];
        else
            alt_is3 = freq_reg[spcps_pkg::DS_3] > freq_reg[spcps_pkg::DS_5];
        alt_sel  = alt_is3 ? spcps_pkg::DS_3 : spcps_pkg::DS_5;
        take_alt = (sat_reg[spcps_pkg::DS_2]
                    || (spcps_pkg::TGT_W'(freq_reg[spcps_pkg::DS_2]) != f_reg))
                   && (sat_reg[spcps_pkg::DS_2]
                       || (!sat_reg[alt_sel]
                           && (freq_reg[alt_sel] > freq_reg[spcps_pkg::DS_2])));
        best_sel = take_alt ? alt_sel : spcps_pkg::DS_2;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (sysclk)
            begin
                ach_reg  <= cpu_reg;
                sys_reg  <= 1'b1;
                pm1_reg  <= '0;
                dm1_reg  <= '0;
                rerr_reg <= 1'b0;
            end
            else
            begin
                ach_reg  <= freq_reg[best_sel];
                sys_reg  <= 1'b0;
                pm1_reg  <= PRESCALE_BITS'(pre_reg[best_sel] - PW'(1));
                dm1_reg  <= spcps_pkg::div_value(best_sel) - 3'd1;
                rerr_reg <= sat_reg[best_sel];
            end
        end
    end

    assign stat.sysclk   = sysclk;
    assign stat.div_done = div_done;

    assign achieved_freq_hz   = ach_reg;
    assign sysclk_mode        = sys_reg;
    assign prescale_minus_one = pm1_reg;
    assign divisor_minus_one  = dm1_reg;
    assign range_error        = rerr_reg;

endmodule

FILE: rtl/spcps_ctrl.sv
// Controller: sequences the nine divisions (start, need, frequency for divisors
// 2, 3 and 5) and owns both handshakes. Depends on spcps_pkg.
`timescale 1ns / 1ps

module spcps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  spcps_pkg::stat_t  stat,
    output spcps_pkg::cmd_t   cmd
);

    spcps_pkg::state_t state_reg, state_next;
    spcps_pkg::dkind_t kind_reg, kind_next;
    spcps_pkg::dsel_t  dsel_reg, dsel_next;
    logic              ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spcps_pkg::S_IDLE;
            kind_reg  <= spcps_pkg::DK_START;
            dsel_reg  <= spcps_pkg::DS_2;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            dsel_reg  <= dsel_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        dsel_next   = dsel_reg;
        ov_next     = ov_reg && out_stall;
        in_stall    = 1'b1;
        cmd.capture = 1'b0;
        cmd.div_go  = 1'b0;
        cmd.kind    = kind_reg;
        cmd.dsel    = dsel_reg;
        cmd.finish  = 1'b0;
        unique case (state_reg)
            spcps_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = spcps_pkg::S_CHECK;
                end
            end
            spcps_pkg::S_CHECK:
            begin
                kind_next = spcps_pkg::DK_START;
                dsel_next = spcps_pkg::DS_2;
                state_next = stat.sysclk ? spcps_pkg::S_FIN : spcps_pkg::S_GO;
            end
            spcps_pkg::S_GO:
            begin
                cmd.div_go = 1'b1;
                state_next = spcps_pkg::S_WAIT;
            end
            spcps_pkg::S_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = spcps_pkg::S_GO;
                    unique case (kind_reg)
                        spcps_pkg::DK_START: kind_next = spcps_pkg::DK_NEED;
                        spcps_pkg::DK_NEED:  kind_next = spcps_pkg::DK_FREQ;
                        default:
                        begin
                            kind_next = spcps_pkg::DK_START;
                            unique case (dsel_reg)
                                spcps_pkg::DS_2: dsel_next = spcps_pkg::DS_3;
                                spcps_pkg::DS_3: dsel_next = spcps_pkg::DS_5;
                                default:         state_next = spcps_pkg::S_FIN;
                            endcase
                        end
                    endcase
                end
            end
            spcps_pkg::S_FIN:
            begin
                // hold until the previous result has been taken
                if (!(ov_reg && out_stall))
                begin
                    cmd.finish = 1'b1;
                    ov_next    = 1'b1;
                    state_next = spcps_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spcps_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = ov_reg;

endmodule

FILE: rtl/spi_clock_prescale_search.sv
// Top level of the serial clock prescale search: controller plus datapath.
// Depends on spcps_pkg, spcps_ctrl, spcps_dp (and spcps_div below it).
`timescale 1ns / 1ps

// Picks prescale and divisor (2, 3 or 5) for a requested serial clock from the
// configured system clock (cpu_freq_mhz, reset 80). One request is worked at a
// time. A request at or above the system clock gives system clock mode, with the
// controller going from its check state straight to its finish state. Any other
// request runs nine divisions in turn on one shared radix-2 divider (start,
// minimum and achieved frequency for each of the three divisors). The next
// request may be taken while the last result still waits at the output.
// A prescale above 2^PRESCALE_BITS is saturated and flagged in range_error.
// cpu_freq_mhz is written through cfg_valid/cfg_data, always ready; write it
// only while no request is in flight.
module spi_clock_prescale_search #(
    parameter int PRESCALE_BITS = spcps_pkg::PRESCALE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [spcps_pkg::MHZ_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [spcps_pkg::TGT_W-1:0]  target_freq_hz,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [27:0]                  achieved_freq_hz,
    output logic                         sysclk_mode,
    output logic [PRESCALE_BITS-1:0]     prescale_minus_one,
    output logic [2:0]                   divisor_minus_one,
    output logic                         range_error
);

    spcps_pkg::cmd_t  cmd;
    spcps_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    spcps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    spcps_dp #(
        .PRESCALE_BITS (PRESCALE_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_valid),
        .cfg_data           (cfg_data),
        .target_freq_hz     (target_freq_hz),
        .cmd                (cmd),
        .stat               (stat),
        .achieved_freq_hz   (achieved_freq_hz),
        .sysclk_mode        (sysclk_mode),
        .prescale_minus_one (prescale_minus_one),
        .divisor_minus_one  (divisor_minus_one),
        .range_error        (range_error)
    );

`ifndef SYNTHESIS
    // system clock mode carries no prescale or divisor
    a_sysclk_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sysclk_mode) |->
            (prescale_minus_one == '0 && divisor_minus_one == 3'd0 && !range_error))
        else $error("sysclk result with nonzero fields");

    a_div_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !sysclk_mode) |->
            (divisor_minus_one == 3'd1 || divisor_minus_one == 3'd2
             || divisor_minus_one == 3'd4))
        else $error("bad divisor code");

    // the input is stalled in the cycle after a request is taken, while it is worked
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken on back-to-back cycles");

    a_div_idle_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !stat.div_done)
        else $error("divider finished while idle");
`endif

endmodule

FILE: dv/spi_clock_prescale_search_test.sv
// Self-checking testbench for spi_clock_prescale_search: directed and random serial clock requests,
// checked field by field against a predictor of the prescale/divisor search.
// Depends on rtl/spcps_pkg.sv and the RTL under rtl/.
`timescale 1ns / 1ps

module spi_clock_prescale_search_test;

    localparam int PB          = spcps_pkg::PRESCALE_BITS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 10;

    typedef struct {
        logic [27:0]   freq_hz;
        logic          sysclk;
        logic [PB-1:0] pre_m1;
        logic [2:0]    div_m1;
        logic          range_err;
    } prescale_result_t;

    typedef struct {
        longint unsigned freq;
        longint unsigned pre;
        longint unsigned div;
        bit              sat;
    } divisor_trial_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [spcps_pkg::MHZ_W-1:0]       cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic [spcps_pkg::TGT_W-1:0]       target_freq_hz;
    logic                              out_valid;
    logic                              out_stall;
    logic [27:0]                       achieved_freq_hz;
    logic                              sysclk_mode;
    logic [PB-1:0]                     prescale_minus_one;
    logic [2:0]                        divisor_minus_one;
    logic                              range_error;

    prescale_result_t pending_settings[$];
    logic [7:0]       cpu_mhz;
    bit               steady;
    int               error_count = 0;
    int unsigned      cycle_count = 0;

    spi_clock_prescale_search #(
        .PRESCALE_BITS(PB)
    ) uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .target_freq_hz    (target_freq_hz),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .achieved_freq_hz  (achieved_freq_hz),
        .sysclk_mode       (sysclk_mode),
        .prescale_minus_one(prescale_minus_one),
        .divisor_minus_one (divisor_minus_one),
        .range_error       (range_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic divisor_trial_t try_divisor(input longint unsigned cpu,
                                                   input longint unsigned f,
                                                   input longint unsigned d);
        divisor_trial_t  c;
        longint unsigned lo;
        longint unsigned need;
        longint unsigned maxp;
        maxp  = 64'd1 << PB;
        c.div = d;
        c.sat = 1'b0;
        if (f == 0)
            c.pre = maxp + 1;   // zero request needs an unbounded prescale
        else
        begin
            lo    = cpu / (f * d);
            need  = cpu / (d * (f + 1)) + 1;
            if (lo == 0)
                lo = 1;
            c.pre = (lo > need) ? lo : need;
        end
        if (c.pre > maxp)
        begin
            c.pre = maxp;
            c.sat = 1'b1;
        end
        c.freq = cpu / (c.pre * d);
        return c;
    endfunction

    function automatic prescale_result_t predict_setting(input logic [7:0] mhz,
                                                         input logic [31:0] target);
        prescale_result_t r;
        divisor_trial_t   best;
        divisor_trial_t   c3;
        divisor_trial_t   c5;
        divisor_trial_t   alt;
        longint unsigned  cpu;
        longint unsigned  f;
        cpu = 64'(mhz);
        cpu = cpu * 64'd1000000;
        f   = 64'(target);
        if (f >= cpu)
        begin
            r.freq_hz   = 28'(cpu);
            r.sysclk    = 1'b1;
            r.pre_m1    = '0;
            r.div_m1    = '0;
            r.range_err = 1'b0;
            return r;
        end
        best = try_divisor(cpu, f, 64'd2);
        if (best.sat || best.freq != f)
        begin
            c3 = try_divisor(cpu, f, 64'd3);
            c5 = try_divisor(cpu, f, 64'd5);
            // unsaturated beats saturated; equal speed between 3 and 5 goes to 5
            if (c3.sat && c5.sat)
                alt = c5;
            else if (c3.sat != c5.sat)
                alt = c3.sat ? c5 : c3;
            else
                alt = (c3.freq > c5.freq) ? c3 : c5;
            if (best.sat != alt.sat)
            begin
                if (best.sat)
                    best = alt;
            end
            else if (best.sat)
                best = alt;
            else if (alt.freq > best.freq)
                best = alt;
        end
        r.freq_hz   = 28'(best.freq);
        r.sysclk    = 1'b0;
        r.pre_m1    = PB'(best.pre - 1);
        r.div_m1    = 3'(best.div - 1);
        r.range_err = best.sat;
        return r;
    endfunction

    // ---------------------------------------------------------------- helpers

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [31:0] pick_target(input logic [31:0] cpu_hz);
        int unsigned sel;
        int unsigned p;
        int unsigned d;
        logic [31:0] f;
        sel = $urandom_range(99, 0);
        if (sel < 12)
            f = $urandom();
        else if (sel < 22)
            f = cpu_hz + $urandom_range(3, 0) - 32'd2;
        else if (sel < 55)
            f = $urandom_range(cpu_hz - 1, 1);
        else if (sel < 75)
            f = $urandom() >> $urandom_range(31, 4);
        else if (sel < 88)
        begin
            // land on or just above an exact prescale/divisor product
            case ($urandom_range(2, 0))
                0:       d = 2;
                1:       d = 3;
                default: d = 5;
            endcase
            p = $urandom_range(9000, 1);
            f = cpu_hz / (p * d) + $urandom_range(1, 0);
        end
        else
            f = $urandom_range(cpu_hz / 8000, 1);   // around the saturation bound
        if (f == 0)
            f = 1;
        return f;
    endfunction

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic send_target(input logic [31:0] f);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        target_freq_hz <= f;
        do @(posedge clk); while (in_stall);
        pending_settings.push_back(predict_setting(cpu_mhz, f));
    endtask

    task automatic wait_idle();
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_settings.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cpu_mhz(input logic [7:0] mhz);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= mhz;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cpu_mhz = mhz;
    endtask

    // ---------------------------------------------------------------- result checker

    initial
    begin : result_monitor
        prescale_result_t want;
        int unsigned      hold;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_settings.size() == 0)
                begin
                    $display("%0t ns: unexpected result transfer, achieved_freq_hz %0d",
                             $time, achieved_freq_hz);
                    error_count++;
                end
                else
                begin
                    want = pending_settings.pop_front();
                    report_field("achieved_freq_hz", 64'(want.freq_hz),
                                 64'(achieved_freq_hz));
                    report_field("sysclk_mode", 64'(want.sysclk), 64'(sysclk_mode));
                    report_field("prescale_minus_one", 64'(want.pre_m1),
                                 64'(prescale_minus_one));
                    report_field("divisor_minus_one", 64'(want.div_m1),
                                 64'(divisor_minus_one));
                    report_field("range_error", 64'(want.range_err), 64'(range_error));
                end
            end
            if (steady)
                out_stall <= 1'b0;
            else if (hold != 0)
                hold--;
            else
            begin
                out_stall <= ($urandom_range(2, 0) == 0);
                hold = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // exact divisor 2, divisor 3 win, divisor 5 win, 3/5 tie, just below sysclk
    task automatic test_divisor_choice();
        send_target(32'd40_000_000);
        send_target(32'd1_000_000);
        send_target(32'd26_666_666);
        send_target(32'd16_000_000);
        send_target(32'd5_333_333);
        send_target(32'd79_999_999);
        send_target(32'd3_000_000);
    endtask

    task automatic test_sysclk_edges();
        send_target(32'd80_000_000);
        send_target(32'd80_000_001);
        send_target(32'hFFFF_FFFF);
    endtask

    // all divisors saturated, only divisor 2 saturated, bounds around 8192
    task automatic test_saturation();
        send_target(32'd1);
        send_target(32'd3000);
        send_target(32'd4882);
        send_target(32'd4883);
        send_target(32'd1953);
        send_target(32'd2000);
    endtask

    task automatic test_cpu_extremes();
        write_cpu_mhz(8'd1);
        send_target(32'd1_000_000);
        send_target(32'd999_999);
        send_target(32'd1);
        send_target(32'd333_333);
        write_cpu_mhz(8'd255);
        send_target(32'd255_000_000);
        send_target(32'd254_999_999);
        send_target(32'd1);
        send_target(32'd15_564);
    endtask

    task automatic test_random_sweep();
        logic [7:0]  mhz;
        logic [31:0] cpu_hz;
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph == 1)
                mhz = 8'd1;
            else if (ph == 2)
                mhz = 8'd255;
            else
                mhz = 8'($urandom_range(255, 1));
            write_cpu_mhz(mhz);
            cpu_hz = 32'(cpu_mhz) * 32'd1000000;
            for (int i = 0; i < 105; i++)
            begin
                steady = (i >= 60 && i < 85);
                send_target(pick_target(cpu_hz));
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        target_freq_hz = '0;
        steady         = 1'b0;
        cpu_mhz        = spcps_pkg::CPU_MHZ_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_divisor_choice();
        test_sysclk_edges();
        test_saturation();
        test_cpu_extremes();
        test_random_sweep();

        wait_idle();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
